@@ sv/polar_remap_coordinate_generator_macros.svh @@
// Assertion macros shared by the polar remap coordinate generator.
`ifndef POLAR_REMAP_COORDINATE_GENERATOR_MACROS_SVH
`define POLAR_REMAP_COORDINATE_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PRCG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/prcg_pkg.sv @@
// Types, constants and the arctangent table of the polar remap coordinate generator.
package prcg_pkg;

  localparam int SQRT_STEPS = 30;
  localparam int DIV_STEPS  = 54;
  localparam int ATAN_LEN   = 24;
  localparam logic [22:0] OUT_LIMIT = 23'd4194304;

  typedef enum logic [1:0] {
    CFG_OUTPUT_SIZE  = 2'd0,
    CFG_RADIUS_SCALE = 2'd1,
    CFG_SOURCE_WIDTH = 2'd2,
    CFG_SOURCE_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic        [22:0] source_x_q8;
    logic signed [23:0] source_y_q8;
  } out_word_t;

  // Angle and radius front end: CORDIC vectoring state next to the square-root state.
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               ax_zero;
    logic               ay_zero;
    logic               dx_neg;
    logic               dy_neg;
    logic        [27:0] rsq;
    logic        [31:0] srem;
    logic        [29:0] sroot;
  } cordic_t;

  // Divider back end: the finished angle rides along with the long division.
  typedef struct packed {
    logic [32:0] t;
    logic        rq_zero;
    logic [28:0] rem;
    logic [53:0] nq;
  } div_t;

  // atan(2^-i) in turns scaled by 2^32.
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/polar_remap_coordinate_generator.sv @@
// Top level of the polar remap coordinate generator: a fully pipelined CORDIC, root and divider.
//
// Channel | Direction | Handshake               | Word
// cfg     | in        | cfg_we_i                | cfg_addr_i, cfg_wdata_i
// in      | in        | in_valid_i / in_ready_o | in_word_i (pixel_x, pixel_y)
// out     | out       | out_valid_o / out_ready_i | out_word_o (source_x_q8, source_y_q8)
//
// One word enters per cycle unless the output stalls. Path: entry register, 30 root stages,
// angle register, 54 restoring divider stages, then the multiply and output registers.
// Reset clears all valid bits and loads the register defaults.
// A stall at the output freezes every stage at once, so nothing is lost or repeated.
`include "polar_remap_coordinate_generator_macros.svh"

module polar_remap_coordinate_generator #(
  parameter int COORD_FRAC_BITS = 8,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_addr_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  prcg_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output prcg_pkg::out_word_t  out_word_o
);

  localparam int HfW = 15 + COORD_FRAC_BITS;

  logic [12:0] output_size_q;
  logic [15:0] radius_scale_q;
  logic [14:0] source_width_q;
  logic [14:0] source_height_q;
  logic [28:0] den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_size_q   <= 13'd1024;
      radius_scale_q  <= 16'd256;
      source_width_q  <= 15'd4096;
      source_height_q <= 15'd1024;
      den_q           <= 29'd262144;
    end else begin
      den_q <= 29'(output_size_q * radius_scale_q);
      if (cfg_we_i) begin
        case (cfg_addr_i)
          prcg_pkg::CFG_OUTPUT_SIZE:   output_size_q   <= cfg_wdata_i[12:0];
          prcg_pkg::CFG_RADIUS_SCALE:  radius_scale_q  <= cfg_wdata_i;
          prcg_pkg::CFG_SOURCE_WIDTH:  source_width_q  <= cfg_wdata_i[14:0];
          prcg_pkg::CFG_SOURCE_HEIGHT: source_height_q <= cfg_wdata_i[14:0];
          default: ;
        endcase
      end
    end
  end

  logic adv;
  logic ov_q;
  logic mv_q;
  prcg_pkg::out_word_t out_q;

  assign adv         = !ov_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = ov_q;
  assign out_word_o  = out_q;

  // Entry stage: offsets from the centre in half pixels.
  logic signed [13:0] dx2;
  logic signed [13:0] dy2;
  logic        [12:0] ax;
  logic        [12:0] ay;
  prcg_pkg::cordic_t  entry;

  always_comb begin
    dx2 = $signed({1'b0, in_word_i.pixel_x, 1'b0}) - $signed({1'b0, output_size_q});
    dy2 = $signed({1'b0, in_word_i.pixel_y, 1'b0}) - $signed({1'b0, output_size_q});
    ax  = dx2[13] ? 13'(-dx2) : dx2[12:0];
    ay  = dy2[13] ? 13'(-dy2) : dy2[12:0];
    entry         = '0;
    entry.x       = $signed({5'b0, ax, 16'b0});
    entry.y       = $signed({5'b0, ay, 16'b0});
    entry.ax_zero = (ax == '0);
    entry.ay_zero = (ay == '0);
    entry.dx_neg  = dx2[13];
    entry.dy_neg  = dy2[13];
    entry.rsq     = 28'(ax * ax) + 28'(ay * ay);
  end

  logic              av_q [prcg_pkg::SQRT_STEPS+1];
  prcg_pkg::cordic_t a_q  [prcg_pkg::SQRT_STEPS+1];
  logic              bv_q [prcg_pkg::DIV_STEPS+1];
  prcg_pkg::div_t    b_q  [prcg_pkg::DIV_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q[0] <= 1'b0;
    end else if (adv) begin
      av_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q[0] <= entry;
    end
  end

  // One CORDIC step and one root digit per stage; CORDIC passes through after its last step.
  for (genvar k = 0; k < prcg_pkg::SQRT_STEPS; k++) begin : g_front
    prcg_pkg::cordic_t  nxt;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] at;
    logic        [33:0] cand;
    logic        [33:0] trial;

    always_comb begin
      nxt   = a_q[k];
      xs    = a_q[k].x >>> k;
      ys    = a_q[k].y >>> k;
      at    = $signed({4'b0, prcg_pkg::atan_turn(5'(k))});
      if (k < CORDIC_STEPS) begin
        if (!a_q[k].y[33]) begin
          nxt.x = a_q[k].x + ys;
          nxt.y = a_q[k].y - xs;
          nxt.z = a_q[k].z + at;
        end else begin
          nxt.x = a_q[k].x - ys;
          nxt.y = a_q[k].y + xs;
          nxt.z = a_q[k].z - at;
        end
      end
      cand  = {a_q[k].srem, a_q[k].rsq[27:26]};
      trial = {2'b0, a_q[k].sroot, 2'b01};
      nxt.rsq = {a_q[k].rsq[25:0], 2'b00};
      if (cand >= trial) begin
        nxt.srem  = 32'(cand - trial);
        nxt.sroot = {a_q[k].sroot[28:0], 1'b1};
      end else begin
        nxt.srem  = cand[31:0];
        nxt.sroot = {a_q[k].sroot[28:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        av_q[k+1] <= 1'b0;
      end else if (adv) begin
        av_q[k+1] <= av_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        a_q[k+1] <= nxt;
      end
    end
  end

  // Angle stage: clamp the quadrant angle and unfold it to a full turn.
  localparam int Last = prcg_pkg::SQRT_STEPS;
  logic        [30:0] qa;
  prcg_pkg::div_t     bstart;

  always_comb begin
    if (a_q[Last].ay_zero) begin
      qa = '0;
    end else if (a_q[Last].ax_zero) begin
      qa = 31'h4000_0000;
    end else if (a_q[Last].z[33]) begin
      qa = '0;
    end else if (a_q[Last].z > 34'sh0_4000_0000) begin
      qa = 31'h4000_0000;
    end else begin
      qa = a_q[Last].z[30:0];
    end
    bstart = '0;
    if (!a_q[Last].dx_neg) begin
      bstart.t = a_q[Last].dy_neg ? 33'h0_8000_0000 - {2'b0, qa}
                                  : 33'h0_8000_0000 + {2'b0, qa};
    end else begin
      bstart.t = a_q[Last].dy_neg ? {2'b0, qa} : 33'h1_0000_0000 - {2'b0, qa};
    end
    bstart.rq_zero = (a_q[Last].sroot == '0);
    bstart.nq      = {a_q[Last].sroot, 24'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q[0] <= 1'b0;
    end else if (adv) begin
      bv_q[0] <= av_q[Last];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_q[0] <= bstart;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < prcg_pkg::DIV_STEPS; k++) begin : g_div
    prcg_pkg::div_t nxt;
    logic [29:0]    cand;

    always_comb begin
      nxt  = b_q[k];
      cand = {b_q[k].rem, b_q[k].nq[53]};
      if (cand >= {1'b0, den_q}) begin
        nxt.rem = 29'(cand - {1'b0, den_q});
        nxt.nq  = {b_q[k].nq[52:0], 1'b1};
      end else begin
        nxt.rem = cand[28:0];
        nxt.nq  = {b_q[k].nq[52:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        bv_q[k+1] <= 1'b0;
      end else if (adv) begin
        bv_q[k+1] <= bv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        b_q[k+1] <= nxt;
      end
    end
  end

  // Multiply stage.
  localparam int DLast = prcg_pkg::DIV_STEPS;
  logic [HfW-1:0]    uhf;
  logic [47:0]       sxp_q;
  logic [22+HfW-1:0] hp_q;
  logic [32+HfW-1:0] lp_q;
  logic              rqz_q;

  assign uhf = {source_height_q, COORD_FRAC_BITS'(0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (adv) begin
      mv_q <= bv_q[DLast];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sxp_q <= 48'(b_q[DLast].t * source_width_q);
      hp_q  <= (22+HfW)'(b_q[DLast].nq[53:32] * uhf);
      lp_q  <= (32+HfW)'(b_q[DLast].nq[31:0] * uhf);
      rqz_q <= b_q[DLast].rq_zero;
    end
  end

  // Output stage: rounding, subtraction and saturation.
  logic        [63:0] sx_sum;
  logic        [31:0] sx_sh;
  logic        [63:0] lp_sum;
  logic        [63:0] term;
  logic signed [63:0] sy_full;
  prcg_pkg::out_word_t res;

  always_comb begin
    sx_sum = (64'(sxp_q) << COORD_FRAC_BITS) + 64'h8000_0000;
    sx_sh  = sx_sum[63:32];
    lp_sum = 64'(lp_q) + 64'h8000_0000;
    term   = 64'(hp_q) + {32'b0, lp_sum[63:32]};
    if (den_q == '0) begin
      sy_full = rqz_q ? $signed(64'(uhf)) : -64'sd4194304;
    end else if (term > 64'h100_0000_0000) begin
      sy_full = -64'sd4194304;
    end else begin
      sy_full = $signed(64'(uhf)) - $signed(term);
    end
    res.source_x_q8 = (sx_sh > 32'(prcg_pkg::OUT_LIMIT)) ? prcg_pkg::OUT_LIMIT : sx_sh[22:0];
    if (sy_full > 64'sd4194304) begin
      res.source_y_q8 = 24'sd4194304;
    end else if (sy_full < -64'sd4194304) begin
      res.source_y_q8 = -24'sd4194304;
    end else begin
      res.source_y_q8 = sy_full[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  `PRCG_ASSERT_NOW(a_root_rem, av_q[Last], a_q[Last].srem <= {1'b0, a_q[Last].sroot, 1'b0}, "root remainder above bound")
  `PRCG_ASSERT_NOW(a_div_rem, bv_q[DLast] && den_q != '0, b_q[DLast].rem < den_q, "divider remainder not below divisor")
  `PRCG_ASSERT_NOW(a_turn_range, bv_q[0], b_q[0].t <= 33'h1_0000_0000, "angle beyond one turn")
  `PRCG_ASSERT_NOW(a_out_range, out_valid_o, out_word_o.source_y_q8 <= 24'sd4194304 && out_word_o.source_y_q8 >= -24'sd4194304, "row coordinate not saturated")
  `PRCG_ASSERT_NEXT(a_out_load, mv_q && adv, ov_q, "multiply stage word not moved to output")

endmodule

@@ verif/polar_remap_coordinate_generator_test.sv @@
// Self-checking testbench of the polar remap coordinate generator.
`timescale 1ns / 100ps

module polar_remap_coordinate_generator_test;

  localparam longint SAT = 64'sd4194304;

  // Tracks the register settings and the coordinates that the block still owes.
  class remap_scoreboard;
    longint unsigned     out_size, scale_q8, src_w, src_h;
    prcg_pkg::out_word_t pending_coords[$];
    int                  errors;
    int                  checked;
    longint              arc_table[prcg_pkg::ATAN_LEN];

    function new();
      arc_table = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                    10679838, 5340245, 2670163, 1335087, 667544, 333772,
                    166886, 83443, 41722, 20861, 10430, 5215,
                    2608, 1304, 652, 326, 163, 81};
      out_size = 1024;
      scale_q8 = 256;
      src_w    = 4096;
      src_h    = 1024;
    endfunction

    function void set_reg(prcg_pkg::cfg_idx_e idx, logic [15:0] val);
      case (idx)
        prcg_pkg::CFG_OUTPUT_SIZE:   out_size = val[12:0];
        prcg_pkg::CFG_RADIUS_SCALE:  scale_q8 = val;
        prcg_pkg::CFG_SOURCE_WIDTH:  src_w    = val[14:0];
        prcg_pkg::CFG_SOURCE_HEIGHT: src_h    = val[14:0];
        default: ;
      endcase
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // First-quadrant angle in turns scaled by 2^32.
    function longint quadrant_turns(longint ax, longint ay);
      longint x, y, z, xs, ys;
      z = 0;
      if (ay == 0) return 0;
      if (ax == 0) return 64'sd1 << 30;
      x = ax * 65536;
      y = ay * 65536;
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + arc_table[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - arc_table[i];
        end
      end
      if (z < 0) z = 0;
      if (z > (64'sd1 << 30)) z = 64'sd1 << 30;
      return z;
    endfunction

    function prcg_pkg::out_word_t map_pixel(prcg_pkg::in_word_t w);
      longint              dx2, dy2, ax, ay, ang, hf, sy;
      longint unsigned     t, sx, rq, den, ratio, hi, lo, term;
      prcg_pkg::out_word_t r;
      dx2 = 2 * longint'(w.pixel_x) - longint'(out_size);
      dy2 = 2 * longint'(w.pixel_y) - longint'(out_size);
      ax  = dx2 < 0 ? -dx2 : dx2;
      ay  = dy2 < 0 ? -dy2 : dy2;
      ang = quadrant_turns(ax, ay);
      if (dx2 >= 0) t = dy2 >= 0 ? (64'd1 << 31) + ang : (64'd1 << 31) - ang;
      else          t = dy2 >= 0 ? (64'd1 << 32) - ang : ang;
      sx = (((t * src_w) << 8) + (64'd1 << 31)) >> 32;
      if (sx > SAT) sx = SAT;
      rq  = root_floor(longint'(ax * ax + ay * ay) << 32);
      den = out_size * scale_q8;
      hf  = longint'(src_h << 8);
      if (den == 0) begin
        sy = rq == 0 ? hf : -SAT;
      end else begin
        ratio = (rq << 24) / den;
        hi    = ratio >> 32;
        lo    = ratio & 64'hFFFF_FFFF;
        term  = hi * hf + ((lo * hf + (64'd1 << 31)) >> 32);
        if (term > (64'd1 << 40)) sy = -SAT;
        else                      sy = hf - longint'(term);
      end
      if (sy > SAT)  sy = SAT;
      if (sy < -SAT) sy = -SAT;
      r.source_x_q8 = sx[22:0];
      r.source_y_q8 = sy[23:0];
      return r;
    endfunction

    function void note_pixel(prcg_pkg::in_word_t w);
      pending_coords = {pending_coords, map_pixel(w)};
    endfunction

    task report(string what);
      errors++;
      $display("mismatch @%0t: %s", $realtime, what);
    endtask

    task check_result(prcg_pkg::out_word_t got);
      prcg_pkg::out_word_t exp_w;
      if (pending_coords.size() == 0) begin
        report($sformatf("unexpected word %h", got));
        return;
      end
      exp_w = pending_coords.pop_front();
      checked++;
      if (got.source_x_q8 !== exp_w.source_x_q8)
        report($sformatf("source_x_q8 got %0d want %0d", got.source_x_q8, exp_w.source_x_q8));
      if (got.source_y_q8 !== exp_w.source_y_q8)
        report($sformatf("source_y_q8 got %0d want %0d",
                         got.source_y_q8, exp_w.source_y_q8));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_addr_i = '0;
  logic [15:0]         cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  prcg_pkg::in_word_t  in_word_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  prcg_pkg::out_word_t out_word_o;

  remap_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_cycles = 0;
  int  sent = 0;

  polar_remap_coordinate_generator uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_word_o);
  end

  task write_reg(prcg_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task send_pixel(logic [11:0] px, logic [11:0] py);
    prcg_pkg::in_word_t w;
    w.pixel_x = px;
    w.pixel_y = py;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(negedge clk_i); while (!in_ready_o);
    sb.note_pixel(w);
    sent++;
    @(posedge clk_i);
  endtask

  task drain;
    in_valid_i <= 1'b0;
    while (sb.pending_coords.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task random_pixels(int count);
    int lim;
    for (int k = 0; k < count; k++) begin
      // Mostly positions inside the image; some anywhere in the field range.
      lim = (sb.out_size > 0 && sb.out_size <= 4096) ? int'(sb.out_size) - 1 : 4095;
      if ($urandom_range(3) == 0) send_pixel(12'($urandom), 12'($urandom));
      else send_pixel(12'($urandom_range(lim)), 12'($urandom_range(lim)));
    end
  endtask

  initial begin
    logic [15:0] cfg_set[8][4];
    cfg_set = '{'{16'd4096, 16'd65535, 16'd16384, 16'd16384},
                '{16'd1, 16'd1, 16'd1, 16'd1},
                '{16'd0, 16'd256, 16'd4096, 16'd1024},
                '{16'd512, 16'd0, 16'd640, 16'd480},
                '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                '{16'd2, 16'd128, 16'd9999, 16'd77},
                '{16'd300, 16'd384, 16'd2048, 16'd300},
                '{16'd4000, 16'd256, 16'd16384, 16'd16384}};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed and random words under the reset settings.
    send_idle_pct = 23;
    recv_idle_pct = 84;
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(0, 4095);
    send_pixel(4095, 0);
    send_pixel(512, 512);
    send_pixel(0, 512);
    send_pixel(100, 512);
    send_pixel(1023, 512);
    send_pixel(512, 0);
    send_pixel(512, 1023);
    send_pixel(1023, 1023);
    send_pixel(2048, 3000);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    random_pixels(60);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      for (int r = 0; r < 4; r++) write_reg(prcg_pkg::cfg_idx_e'(r), cfg_set[ph][r]);
      cfg_we_i <= 1'b0;
      if (ph < 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 84;
      end else if (ph < 6) begin
        send_idle_pct = 84;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_pixel(cfg_set[ph][0][12:1], cfg_set[ph][0][12:1]);
      send_pixel(0, cfg_set[ph][0][12:1]);
      if (ph == 6) hold_cycles = 300;
      random_pixels(ph == 6 ? 150 : 80);
      drain();
    end

    $display("covered %0d pixels over nine register settings, %0d coordinate pairs checked",
             sent, sb.checked);
    $display("settings included zero radius, masking writes and sizes at both ends");
    if (sb.errors == 0 && sb.pending_coords.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ polar_remap_coordinate_generator.f @@
+incdir+sv
sv/prcg_pkg.sv
sv/polar_remap_coordinate_generator.sv
verif/polar_remap_coordinate_generator_test.sv
